>>> hdl/svg_dim_pkg.sv
// Shared types, byte codes and key matcher for the SVG header dimension scanner.
`timescale 1ns / 1ps

package svg_dim_pkg;

  // Default width of a parsed dimension
  localparam int VALUE_BITS_DEF = 24;

  // Longest key, in bytes
  localparam int KEY_MAX_LEN = 9;

  // Keys, first character in the most significant byte, right aligned
  localparam logic [8*KEY_MAX_LEN-1:0] KEY_OPEN = 72'("<svg");
  localparam logic [8*KEY_MAX_LEN-1:0] KEY_VB   = 72'("viewBox=\"");
  localparam logic [8*KEY_MAX_LEN-1:0] KEY_W    = 72'("width=\"");
  localparam logic [8*KEY_MAX_LEN-1:0] KEY_H    = 72'("height=\"");
  localparam int KEY_OPEN_LEN = 4;
  localparam int KEY_VB_LEN   = 9;
  localparam int KEY_W_LEN    = 7;
  localparam int KEY_H_LEN    = 8;

  // Byte codes
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;

  // Result status codes
  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  // Document scan state
  typedef enum logic [3:0] {
    MODE_SEEK  = 4'b0001,
    MODE_TAG   = 4'b0010,
    MODE_VALUE = 4'b0100,
    MODE_DONE  = 4'b1000
  } scan_mode_t;

  // Number parse state
  typedef enum logic [3:0] {
    PH_DEC  = 4'b0001,
    PH_FRAC = 4'b0010,
    PH_UNIT = 4'b0100,
    PH_END  = 4'b1000
  } num_phase_t;

  // Which attribute value is being parsed
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_VB   = 2'd1,
    KIND_W    = 2'd2,
    KIND_H    = 2'd3
  } value_kind_t;

  // Next match length of a key after byte b, with prog bytes already matched.
  // Takes the longest prefix of the key that ends the text seen so far.
  function automatic logic [3:0] key_step(input logic [8*KEY_MAX_LEN-1:0] pat,
                                          input int len,
                                          input logic [3:0] prog,
                                          input logic [7:0] b);
    int         p;
    logic       ok;
    logic [3:0] res;
    p   = (int'(prog) >= len) ? 0 : int'(prog);
    res = '0;
    for (int k = 1; k <= KEY_MAX_LEN; k++) begin
      if (k <= p + 1) begin
        ok = (pat[8*(len-k) +: 8] == b);
        for (int i = 0; i < KEY_MAX_LEN - 1; i++) begin
          if (i + 1 < k) begin
            if (pat[8*(len-1-i) +: 8] != pat[8*(len-1-(p+1-k+i)) +: 8]) begin
              ok = 1'b0;
            end
          end
        end
        if (ok) begin
          res = 4'(k);
        end
      end
    end
    return res;
  endfunction

endpackage

>>> hdl/svg_header_dimension_scanner_top.sv
// SVG header dimension scanner: byte register, single-pass parser, result register.
// Path: the byte beat that causes a result is held in the byte register, and the result
// beat it yields is then presented from the result register.
// Throughput: one byte per cycle; in_stall rises only while a byte waits and the
// result register holds a beat that out_stall keeps from leaving.
// Reset: rst_n is synchronous and clears all parser state; the final byte of each
// document returns the parser to the same state.
`timescale 1ns / 1ps

module svg_header_dimension_scanner_top #(
  parameter int VALUE_BITS = svg_dim_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_byte_value,
  input  logic                  in_last_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [VALUE_BITS-1:0] out_width_value,
  output logic [VALUE_BITS-1:0] out_height_value,
  output logic                  out_width_known,
  output logic                  out_height_known
);

  localparam int VB = VALUE_BITS;
  localparam logic [VB-1:0] VALUE_MAX = {VB{1'b1}};

  // Byte register
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // Result register
  logic                 out_v_r;
  svg_dim_pkg::status_t out_status_r;
  logic [VB-1:0]        out_w_r;
  logic [VB-1:0]        out_h_r;
  logic                 out_wk_r;
  logic                 out_hk_r;

  // Parser state
  svg_dim_pkg::scan_mode_t  mode_r, mode_nxt;
  logic [2:0]               tag_prog_r, tag_prog_nxt;
  logic [3:0]               vb_prog_r, vb_prog_nxt;
  logic [2:0]               w_prog_r, w_prog_nxt;
  logic [3:0]               h_prog_r, h_prog_nxt;
  svg_dim_pkg::value_kind_t kind_r, kind_nxt;
  svg_dim_pkg::num_phase_t  phase_r, phase_nxt;
  logic                     seen_r, seen_nxt;
  logic [VB-1:0]            acc_r, acc_nxt;
  logic [1:0]               vb_idx_r, vb_idx_nxt;
  logic [VB-1:0]            vb_w_r, vb_w_nxt;
  logic [VB-1:0]            w_store_r, w_store_nxt;
  logic [VB-1:0]            h_store_r, h_store_nxt;
  logic                     w_flag_r, w_flag_nxt;
  logic                     h_flag_r, h_flag_nxt;

  logic                 fire;
  logic                 advance;
  logic                 in_take;
  logic                 emit;
  svg_dim_pkg::status_t emit_status;

  // Byte classes
  logic [7:0] b;
  logic       is_digit;
  logic       is_lower;
  logic       is_sep;

  // Saturating decimal accumulate
  logic [VB+3:0] acc_prod;
  logic [VB-1:0] acc_dig;

  // Key matcher outputs
  logic [3:0] open_m;
  logic [3:0] vb_m;
  logic [3:0] w_m;
  logic [3:0] h_m;

  // Handshake: the parser moves when the result register can take a beat
  assign advance   = !out_v_r || !out_stall;
  assign fire      = in_v_r && advance;
  assign in_stall  = in_v_r && !advance;
  assign in_take   = in_valid && !in_stall;

  assign b        = in_byte_r;
  assign is_digit = (b >= svg_dim_pkg::CH_ZERO) && (b <= svg_dim_pkg::CH_NINE);
  assign is_lower = (b >= svg_dim_pkg::CH_LOW_A) && (b <= svg_dim_pkg::CH_LOW_Z);
  assign is_sep   = (b == svg_dim_pkg::CH_SPACE) || (b == svg_dim_pkg::CH_COMMA);

  assign acc_prod = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1)
                  + (VB+4)'(b[3:0]);
  assign acc_dig  = (|acc_prod[VB+3:VB]) ? VALUE_MAX : acc_prod[VB-1:0];

  assign open_m = svg_dim_pkg::key_step(svg_dim_pkg::KEY_OPEN, svg_dim_pkg::KEY_OPEN_LEN,
                                        {1'b0, tag_prog_r}, b);
  assign vb_m   = svg_dim_pkg::key_step(svg_dim_pkg::KEY_VB, svg_dim_pkg::KEY_VB_LEN,
                                        vb_prog_r, b);
  assign w_m    = svg_dim_pkg::key_step(svg_dim_pkg::KEY_W, svg_dim_pkg::KEY_W_LEN,
                                        {1'b0, w_prog_r}, b);
  assign h_m    = svg_dim_pkg::key_step(svg_dim_pkg::KEY_H, svg_dim_pkg::KEY_H_LEN,
                                        h_prog_r, b);

  // Parse one byte
  always_comb begin
    logic end_check;
    mode_nxt     = mode_r;
    tag_prog_nxt = tag_prog_r;
    vb_prog_nxt  = vb_prog_r;
    w_prog_nxt   = w_prog_r;
    h_prog_nxt   = h_prog_r;
    kind_nxt     = kind_r;
    phase_nxt    = phase_r;
    seen_nxt     = seen_r;
    acc_nxt      = acc_r;
    vb_idx_nxt   = vb_idx_r;
    vb_w_nxt     = vb_w_r;
    w_store_nxt  = w_store_r;
    h_store_nxt  = h_store_r;
    w_flag_nxt   = w_flag_r;
    h_flag_nxt   = h_flag_r;
    emit         = 1'b0;
    emit_status  = svg_dim_pkg::ST_NOT_FOUND;
    end_check    = 1'b0;

    case (mode_r)
      svg_dim_pkg::MODE_SEEK: begin
        if (open_m == 4'(svg_dim_pkg::KEY_OPEN_LEN)) begin
          tag_prog_nxt = '0;
          mode_nxt     = svg_dim_pkg::MODE_TAG;
        end else begin
          tag_prog_nxt = open_m[2:0];
        end
      end

      svg_dim_pkg::MODE_TAG: begin
        if (b == svg_dim_pkg::CH_GT) begin
          emit        = 1'b1;
          emit_status = (w_flag_r && h_flag_r) ? svg_dim_pkg::ST_FOUND
                                               : svg_dim_pkg::ST_NOT_FOUND;
          mode_nxt    = svg_dim_pkg::MODE_DONE;
        end else begin
          vb_prog_nxt = vb_m;
          w_prog_nxt  = w_m[2:0];
          h_prog_nxt  = h_m;
          if (vb_m == 4'(svg_dim_pkg::KEY_VB_LEN) || w_m == 4'(svg_dim_pkg::KEY_W_LEN)
              || h_m == 4'(svg_dim_pkg::KEY_H_LEN)) begin
            if (vb_m == 4'(svg_dim_pkg::KEY_VB_LEN)) begin
              kind_nxt = svg_dim_pkg::KIND_VB;
            end else if (w_m == 4'(svg_dim_pkg::KEY_W_LEN)) begin
              kind_nxt = svg_dim_pkg::KIND_W;
            end else begin
              kind_nxt = svg_dim_pkg::KIND_H;
            end
            vb_prog_nxt = '0;
            w_prog_nxt  = '0;
            h_prog_nxt  = '0;
            phase_nxt   = svg_dim_pkg::PH_DEC;
            seen_nxt    = 1'b0;
            acc_nxt     = '0;
            vb_idx_nxt  = '0;
            mode_nxt    = svg_dim_pkg::MODE_VALUE;
          end
        end
      end

      svg_dim_pkg::MODE_VALUE: begin
        if (b != svg_dim_pkg::CH_QUOTE) begin
          if (kind_r == svg_dim_pkg::KIND_VB) begin
            // viewBox number list
            case (phase_r)
              svg_dim_pkg::PH_DEC: begin
                if (is_digit) begin
                  acc_nxt  = acc_dig;
                  seen_nxt = 1'b1;
                end else if (b == svg_dim_pkg::CH_DOT) begin
                  phase_nxt = svg_dim_pkg::PH_FRAC;
                end else if (!seen_r && (b == svg_dim_pkg::CH_SPACE
                             || (b == svg_dim_pkg::CH_COMMA && vb_idx_r != 2'd0))) begin
                  // skip leading separator
                end else begin
                  end_check = 1'b1;
                end
              end
              svg_dim_pkg::PH_FRAC: begin
                if (!is_digit) begin
                  end_check = 1'b1;
                end
              end
              svg_dim_pkg::PH_UNIT: begin
                end_check = 1'b1;
              end
              default: begin
              end
            endcase
            if (end_check) begin
              if (is_lower) begin
                phase_nxt = svg_dim_pkg::PH_UNIT;
              end else if (!seen_r || vb_idx_r == 2'd3) begin
                phase_nxt = svg_dim_pkg::PH_END;
              end else if (!is_sep) begin
                phase_nxt = svg_dim_pkg::PH_END;
                seen_nxt  = 1'b0;
              end else begin
                if (vb_idx_r == 2'd2) begin
                  vb_w_nxt = acc_r;
                end
                vb_idx_nxt = vb_idx_r + 2'd1;
                acc_nxt    = '0;
                seen_nxt   = 1'b0;
                phase_nxt  = svg_dim_pkg::PH_DEC;
              end
            end
          end else begin
            // width or height length
            case (phase_r)
              svg_dim_pkg::PH_DEC: begin
                if (is_digit) begin
                  acc_nxt  = acc_dig;
                  seen_nxt = 1'b1;
                end else if (b == svg_dim_pkg::CH_DOT) begin
                  phase_nxt = svg_dim_pkg::PH_FRAC;
                end else if (is_lower) begin
                  phase_nxt = svg_dim_pkg::PH_UNIT;
                end else if (!(b == svg_dim_pkg::CH_SPACE && !seen_r)) begin
                  phase_nxt = svg_dim_pkg::PH_END;
                end
              end
              svg_dim_pkg::PH_FRAC: begin
                if (is_lower) begin
                  phase_nxt = svg_dim_pkg::PH_UNIT;
                end else if (!is_digit) begin
                  phase_nxt = svg_dim_pkg::PH_END;
                end
              end
              svg_dim_pkg::PH_UNIT: begin
                if (!is_lower) begin
                  phase_nxt = svg_dim_pkg::PH_END;
                end
              end
              default: begin
              end
            endcase
          end
        end else begin
          // closing quote
          if (kind_r == svg_dim_pkg::KIND_VB && vb_idx_r == 2'd3 && seen_r) begin
            w_store_nxt = vb_w_r;
            h_store_nxt = acc_r;
            w_flag_nxt  = 1'b1;
            h_flag_nxt  = 1'b1;
            emit        = 1'b1;
            emit_status = svg_dim_pkg::ST_FOUND;
            mode_nxt    = svg_dim_pkg::MODE_DONE;
          end else if (kind_r != svg_dim_pkg::KIND_VB && !seen_r) begin
            emit        = 1'b1;
            emit_status = svg_dim_pkg::ST_MALFORMED;
            mode_nxt    = svg_dim_pkg::MODE_DONE;
          end else begin
            if (kind_r == svg_dim_pkg::KIND_W) begin
              w_store_nxt = acc_r;
              w_flag_nxt  = 1'b1;
            end else if (kind_r == svg_dim_pkg::KIND_H) begin
              h_store_nxt = acc_r;
              h_flag_nxt  = 1'b1;
            end
            // back to the tag body
            mode_nxt   = svg_dim_pkg::MODE_TAG;
            kind_nxt   = svg_dim_pkg::KIND_NONE;
            phase_nxt  = svg_dim_pkg::PH_DEC;
            seen_nxt   = 1'b0;
            acc_nxt    = '0;
            vb_idx_nxt = '0;
          end
        end
      end

      default: begin
        // result already given: drop bytes
      end
    endcase

    // Final byte without a result reports not found
    if (in_last_r && !emit && mode_r != svg_dim_pkg::MODE_DONE) begin
      emit        = 1'b1;
      emit_status = svg_dim_pkg::ST_NOT_FOUND;
    end
  end

  // Byte register: hold while stalled, drop once parsed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (fire) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_byte_value;
      in_last_r <= in_last_byte;
    end
  end

  // Parser state: advance per byte, clear on the final byte
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && in_last_r)) begin
      mode_r     <= svg_dim_pkg::MODE_SEEK;
      tag_prog_r <= '0;
      vb_prog_r  <= '0;
      w_prog_r   <= '0;
      h_prog_r   <= '0;
      kind_r     <= svg_dim_pkg::KIND_NONE;
      phase_r    <= svg_dim_pkg::PH_DEC;
      seen_r     <= 1'b0;
      acc_r      <= '0;
      vb_idx_r   <= '0;
      vb_w_r     <= '0;
      w_store_r  <= '0;
      h_store_r  <= '0;
      w_flag_r   <= 1'b0;
      h_flag_r   <= 1'b0;
    end else if (fire) begin
      mode_r     <= mode_nxt;
      tag_prog_r <= tag_prog_nxt;
      vb_prog_r  <= vb_prog_nxt;
      w_prog_r   <= w_prog_nxt;
      h_prog_r   <= h_prog_nxt;
      kind_r     <= kind_nxt;
      phase_r    <= phase_nxt;
      seen_r     <= seen_nxt;
      acc_r      <= acc_nxt;
      vb_idx_r   <= vb_idx_nxt;
      vb_w_r     <= vb_w_nxt;
      w_store_r  <= w_store_nxt;
      h_store_r  <= h_store_nxt;
      w_flag_r   <= w_flag_nxt;
      h_flag_r   <= h_flag_nxt;
    end
  end

  // Result register: load on a result, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire && emit) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_status_r <= emit_status;
      out_w_r      <= w_flag_nxt ? w_store_nxt : '0;
      out_h_r      <= h_flag_nxt ? h_store_nxt : '0;
      out_wk_r     <= w_flag_nxt;
      out_hk_r     <= h_flag_nxt;
    end
  end

  assign out_valid        = out_v_r;
  assign out_status       = out_status_r;
  assign out_width_value  = out_w_r;
  assign out_height_value = out_h_r;
  assign out_width_known  = out_wk_r;
  assign out_height_known = out_hk_r;

endmodule

>>> bench/svg_header_dimension_scanner_top_tb.sv
// Self-checking bench for the SVG header dimension scanner: documents in, one dims beat out.
`timescale 1ns / 1ps

module svg_header_dimension_scanner_top_tb;

  localparam int VB = svg_dim_pkg::VALUE_BITS_DEF;
  localparam logic [VB-1:0] VALUE_MAX = '1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 60;
  localparam string KEY_OPEN_TXT = "<svg";
  localparam string KEY_VB_TXT = "viewBox=\"";
  localparam string KEY_W_TXT = "width=\"";
  localparam string KEY_H_TXT = "height=\"";

  // One result beat as the scanner should report it
  typedef struct packed {
    svg_dim_pkg::status_t status;
    logic [VB-1:0]        wval;
    logic [VB-1:0]        hval;
    logic                 wknown;
    logic                 hknown;
  } dims_t;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  logic [7:0]    in_byte_value;
  logic          in_last_byte;
  logic          out_valid;
  logic          out_stall;
  logic [1:0]    out_status;
  logic [VB-1:0] out_width_value;
  logic [VB-1:0] out_height_value;
  logic          out_width_known;
  logic          out_height_known;

  dims_t      pending_dims[$];
  logic [7:0] doc_bytes[$];
  int         error_count = 0;
  int         cycle_count = 0;
  int         bytes_sent = 0;
  int         hold_request = 0;
  bit         in_gaps = 1'b0;
  bit         out_gaps = 1'b0;

  // Scanner state as the bench tracks it
  svg_dim_pkg::scan_mode_t  scan_mode;
  svg_dim_pkg::num_phase_t  scan_phase;
  svg_dim_pkg::value_kind_t scan_kind;
  int            open_len, vb_len, w_len, h_len, vb_index;
  bit            scan_digit, w_known, h_known, scan_done;
  logic [VB-1:0] scan_acc, vb_width, w_store, h_store;

  svg_header_dimension_scanner_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_value    (in_byte_value),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_width_value  (out_width_value),
    .out_height_value (out_height_value),
    .out_width_known  (out_width_known),
    .out_height_known (out_height_known)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL svg_header_dimension_scanner_top");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  // Longest prefix of key that ends the text seen so far, after byte b
  function automatic int key_next(string key, int prog, logic [7:0] b);
    int  p;
    int  best;
    bit  ok;
    p = (prog >= key.len()) ? 0 : prog;
    best = 0;
    for (int k = 1; k <= p + 1; k++) begin
      ok = (key[k-1] == b);
      for (int i = 0; i + 1 < k; i++) begin
        if (key[i] != key[p + 1 - k + i]) ok = 1'b0;
      end
      if (ok) best = k;
    end
    return best;
  endfunction

  function automatic void clear_scan();
    scan_mode = svg_dim_pkg::MODE_SEEK;
    scan_phase = svg_dim_pkg::PH_DEC;
    scan_kind = svg_dim_pkg::KIND_NONE;
    open_len = 0;
    vb_len = 0;
    w_len = 0;
    h_len = 0;
    vb_index = 0;
    scan_digit = 1'b0;
    scan_acc = '0;
    vb_width = '0;
    w_store = '0;
    h_store = '0;
    w_known = 1'b0;
    h_known = 1'b0;
    scan_done = 1'b0;
  endfunction

  function automatic void start_value();
    scan_phase = svg_dim_pkg::PH_DEC;
    scan_digit = 1'b0;
    scan_acc = '0;
    vb_index = 0;
  endfunction

  function automatic void post_dims(svg_dim_pkg::status_t st);
    dims_t d;
    d.status = st;
    d.wval = w_known ? w_store : '0;
    d.hval = h_known ? h_store : '0;
    d.wknown = w_known;
    d.hknown = h_known;
    pending_dims.push_back(d);
    scan_done = 1'b1;
    scan_mode = svg_dim_pkg::MODE_DONE;
  endfunction

  // Accumulate one decimal digit, saturating at the field maximum
  function automatic void push_digit(logic [7:0] b);
    longint unsigned v;
    v = 64'(scan_acc) * 64'd10 + 64'(b) - 64'(svg_dim_pkg::CH_ZERO);
    scan_acc = (v > 64'(VALUE_MAX)) ? VALUE_MAX : VB'(v);
    scan_digit = 1'b1;
  endfunction

  function automatic void viewbox_char(logic [7:0] b);
    bit digit, lower, sep;
    digit = (b >= svg_dim_pkg::CH_ZERO) && (b <= svg_dim_pkg::CH_NINE);
    lower = (b >= svg_dim_pkg::CH_LOW_A) && (b <= svg_dim_pkg::CH_LOW_Z);
    sep = (b == svg_dim_pkg::CH_SPACE) || (b == svg_dim_pkg::CH_COMMA);
    if (scan_phase == svg_dim_pkg::PH_END) return;
    if (scan_phase == svg_dim_pkg::PH_DEC) begin
      if (digit) begin
        push_digit(b);
        return;
      end
      if (b == svg_dim_pkg::CH_DOT) begin
        scan_phase = svg_dim_pkg::PH_FRAC;
        return;
      end
      // skip separators ahead of a number; a comma may not lead the list
      if (!scan_digit && (b == svg_dim_pkg::CH_SPACE
          || (b == svg_dim_pkg::CH_COMMA && vb_index > 0))) return;
    end else if (scan_phase == svg_dim_pkg::PH_FRAC && digit) begin
      return;
    end
    if (lower) begin
      scan_phase = svg_dim_pkg::PH_UNIT;
      return;
    end
    // b ends the current number
    if (!scan_digit || vb_index >= 3) begin
      scan_phase = svg_dim_pkg::PH_END;
      return;
    end
    if (!sep) begin
      scan_phase = svg_dim_pkg::PH_END;
      scan_digit = 1'b0;
      return;
    end
    if (vb_index == 2) vb_width = scan_acc;
    vb_index++;
    scan_acc = '0;
    scan_digit = 1'b0;
    scan_phase = svg_dim_pkg::PH_DEC;
  endfunction

  function automatic void length_char(logic [7:0] b);
    bit digit, lower;
    digit = (b >= svg_dim_pkg::CH_ZERO) && (b <= svg_dim_pkg::CH_NINE);
    lower = (b >= svg_dim_pkg::CH_LOW_A) && (b <= svg_dim_pkg::CH_LOW_Z);
    case (scan_phase)
      svg_dim_pkg::PH_DEC: begin
        if (digit) push_digit(b);
        else if (b == svg_dim_pkg::CH_DOT) scan_phase = svg_dim_pkg::PH_FRAC;
        else if (lower) scan_phase = svg_dim_pkg::PH_UNIT;
        else if (!(b == svg_dim_pkg::CH_SPACE && !scan_digit)) scan_phase = svg_dim_pkg::PH_END;
      end
      svg_dim_pkg::PH_FRAC: begin
        if (lower) scan_phase = svg_dim_pkg::PH_UNIT;
        else if (!digit) scan_phase = svg_dim_pkg::PH_END;
      end
      svg_dim_pkg::PH_UNIT: begin
        if (!lower) scan_phase = svg_dim_pkg::PH_END;
      end
      default: ;
    endcase
  endfunction

  // Advance the scan by one byte; returns 1 when a result is due
  function automatic bit consume_byte(logic [7:0] b);
    case (scan_mode)
      svg_dim_pkg::MODE_SEEK: begin
        open_len = key_next(KEY_OPEN_TXT, open_len, b);
        if (open_len == KEY_OPEN_TXT.len()) begin
          open_len = 0;
          scan_mode = svg_dim_pkg::MODE_TAG;
        end
        return 1'b0;
      end
      svg_dim_pkg::MODE_TAG: begin
        if (b == svg_dim_pkg::CH_GT) begin
          post_dims((w_known && h_known) ? svg_dim_pkg::ST_FOUND : svg_dim_pkg::ST_NOT_FOUND);
          return 1'b1;
        end
        vb_len = key_next(KEY_VB_TXT, vb_len, b);
        w_len = key_next(KEY_W_TXT, w_len, b);
        h_len = key_next(KEY_H_TXT, h_len, b);
        if (vb_len == KEY_VB_TXT.len()) scan_kind = svg_dim_pkg::KIND_VB;
        else if (w_len == KEY_W_TXT.len()) scan_kind = svg_dim_pkg::KIND_W;
        else if (h_len == KEY_H_TXT.len()) scan_kind = svg_dim_pkg::KIND_H;
        else return 1'b0;
        vb_len = 0;
        w_len = 0;
        h_len = 0;
        start_value();
        scan_mode = svg_dim_pkg::MODE_VALUE;
        return 1'b0;
      end
      svg_dim_pkg::MODE_VALUE: begin
        if (b != svg_dim_pkg::CH_QUOTE) begin
          if (scan_kind == svg_dim_pkg::KIND_VB) viewbox_char(b);
          else length_char(b);
          return 1'b0;
        end
        // closing quote
        if (scan_kind == svg_dim_pkg::KIND_VB) begin
          if (vb_index == 3 && scan_digit) begin
            w_store = vb_width;
            h_store = scan_acc;
            w_known = 1'b1;
            h_known = 1'b1;
            post_dims(svg_dim_pkg::ST_FOUND);
            return 1'b1;
          end
        end else begin
          if (!scan_digit) begin
            post_dims(svg_dim_pkg::ST_MALFORMED);
            return 1'b1;
          end
          if (scan_kind == svg_dim_pkg::KIND_W) begin
            w_store = scan_acc;
            w_known = 1'b1;
          end else begin
            h_store = scan_acc;
            h_known = 1'b1;
          end
        end
        start_value();
        scan_kind = svg_dim_pkg::KIND_NONE;
        scan_mode = svg_dim_pkg::MODE_TAG;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Expected dims for one accepted byte beat
  function automatic void track_dimensions(logic [7:0] b, logic last);
    bit made;
    made = 1'b0;
    if (!scan_done) made = consume_byte(b);
    if (last) begin
      if (!made && !scan_done) post_dims(svg_dim_pkg::ST_NOT_FOUND);
      clear_scan();
    end
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void compare_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      error_count++;
    end
  endfunction

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    dims_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dims.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual status %0d w %0d h %0d",
                 $time, out_status, out_width_value, out_height_value);
        error_count++;
      end else begin
        want = pending_dims.pop_front();
        compare_field("status", 32'(want.status), 32'(out_status));
        compare_field("width_value", 32'(want.wval), 32'(out_width_value));
        compare_field("height_value", 32'(want.hval), 32'(out_height_value));
        compare_field("width_known", 32'(want.wknown), 32'(out_width_known));
        compare_field("height_known", 32'(want.hknown), 32'(out_height_known));
      end
    end
  end

  // Result side back-pressure: random bursts, or one long hold on request
  initial begin
    int span;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        span = hold_request;
        hold_request = 0;
        out_stall <= 1'b1;
        while (span > 0) begin
          @(posedge clk);
          span--;
        end
        out_stall <= 1'b0;
      end else if (out_gaps && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Offer one byte beat and hold it until accepted
  task automatic send_byte(logic [7:0] b, logic last);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_value <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_dimensions(b, last);
    bytes_sent++;
  endtask

  task automatic send_doc_bytes();
    for (int i = 0; i < doc_bytes.size(); i++) send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
  endtask

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) doc_bytes.push_back(s[i]);
  endfunction

  function automatic void put_noise(int n);
    repeat (n) doc_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_digits(int n);
    repeat (n) doc_bytes.push_back(svg_dim_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  task automatic send_doc(string s);
    doc_bytes.delete();
    put_text(s);
    send_doc_bytes();
  endtask

  // Number text: optional leading spaces, digits, then fraction or unit or junk; if allowed, empty or .5
  function automatic void put_number(bit may_be_empty);
    int sel;
    sel = $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) doc_bytes.push_back(svg_dim_pkg::CH_SPACE);
    end
    if (may_be_empty && sel == 0) return;
    if (may_be_empty && sel == 1) begin
      put_text(".5");
      return;
    end
    if (sel == 2) put_digits($urandom_range(8, 10));
    else put_digits($urandom_range(1, 4));
    case ($urandom_range(0, 9))
      0: begin
        doc_bytes.push_back(svg_dim_pkg::CH_DOT);
        put_digits($urandom_range(0, 3));
      end
      1: put_text("px");
      2: put_text(".25mm");
      3: put_text("%");
      4: put_text("PX");
      5: put_text(" ");
      default: ;
    endcase
  endfunction

  function automatic void put_separator();
    case ($urandom_range(0, 11))
      0: put_text(";");
      1: put_text("-");
      2: ;
      default: repeat ($urandom_range(1, 3))
        doc_bytes.push_back($urandom_range(0, 1) ? svg_dim_pkg::CH_SPACE : svg_dim_pkg::CH_COMMA);
    endcase
  endfunction

  function automatic void put_viewbox();
    int count;
    count = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 5) : 4;
    if ($urandom_range(0, 7) == 0) doc_bytes.push_back(svg_dim_pkg::CH_COMMA);
    for (int i = 0; i < count; i++) begin
      if (i > 0) put_separator();
      put_number($urandom_range(0, 9) == 0);
    end
    if ($urandom_range(0, 5) == 0) put_text(" 7 x");
  endfunction

  function automatic void put_attr();
    case ($urandom_range(0, 11))
      0, 1, 2: begin
        put_text(" width=\"");
        put_number(1'b1);
        put_text("\"");
      end
      3, 4, 5: begin
        put_text(" height=\"");
        put_number(1'b1);
        put_text("\"");
      end
      6, 7: begin
        put_text(" viewBox=\"");
        put_viewbox();
        put_text("\"");
      end
      8: put_text(" fill=\"red\"");
      9: put_text(" hheight=\"2\"");
      10: put_text(" widt=\"3\" viewBo");
      default: put_noise($urandom_range(1, 3));
    endcase
  endfunction

  // Mostly well-formed headers with random content; some pure noise
  task automatic random_doc();
    int cut;
    doc_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      put_noise($urandom_range(1, 16));
    end else begin
      case ($urandom_range(0, 4))
        0: put_text("<?xml v=\"1\"?>\n");
        1: put_noise($urandom_range(1, 4));
        2: put_text("<s<sv");
        default: ;
      endcase
      put_text("<svg");
      repeat ($urandom_range(0, 3)) put_attr();
      case ($urandom_range(0, 7))
        0: ;
        1: begin
          cut = $urandom_range(1, doc_bytes.size());
          while (doc_bytes.size() > cut) void'(doc_bytes.pop_back());
        end
        default: begin
          put_text(">");
          put_noise($urandom_range(0, 4));
        end
      endcase
    end
    send_doc_bytes();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_width_height();
    send_doc("<svg width=\"640\" height=\"480\">");
    send_doc("<svg height=\"  12.5px\" width=\"0\">tail");
    send_doc("<svg width=\"99999999999\" height=\"16777215\">");
    send_doc("<svg width=\"7em\">");
  endtask

  task automatic test_viewbox();
    send_doc("<svg viewBox=\"0 0 100 50\">");
    send_doc("<svg viewBox=\",0 0 1 1\" width=\"3\" height=\"4\">");
    send_doc("<svg viewBox=\"1,, 2 ,3.5\">");
    send_doc("<svg viewBox=\"1 2 3;4\" height=\"9\">");
    send_doc("<svg width=\"5\" viewBox=\"0 0 8px 9 junk\">");
  endtask

  task automatic test_malformed_value();
    send_doc("<svg width=\"px\">");
    send_doc("<svg height=\"\">");
  endtask

  task automatic test_key_overlap();
    send_doc("<<svg wwidth=\"3\" hheight=\"4\">");
    send_doc("<s<svg widwidth=\"1\" heheight=\"2\">");
    send_doc("><svg viewviewBox=\"0 0 5 6\"");
  endtask

  task automatic test_early_end();
    send_doc("x");
    send_doc("<sv");
    send_doc("<svg width=\"12");
    send_doc("\200\377");
  endtask

  // Hold the result side while short documents keep arriving
  task automatic test_result_backlog();
    in_gaps = 1'b0;
    out_gaps = 1'b0;
    hold_request = HOLD_CYCLES;
    send_doc("<svg>");
    send_doc("<svg width=\"1\" height=\"2\">x");
  endtask

  task automatic test_random_docs();
    int docs;
    docs = 0;
    in_gaps = 1'b1;
    out_gaps = 1'b1;
    while (docs < 6 || bytes_sent < 600) begin
      random_doc();
      docs++;
    end
  endtask

  task automatic test_quiet_tail();
    in_gaps = 1'b0;
    out_gaps = 1'b0;
    repeat (2) random_doc();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_byte_value <= '0;
    in_last_byte <= 1'b0;
    clear_scan();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    in_gaps = 1'b1;
    out_gaps = 1'b1;
    test_width_height();
    test_viewbox();
    test_malformed_value();
    test_key_overlap();
    test_early_end();
    test_result_backlog();
    test_random_docs();
    test_quiet_tail();
    in_valid <= 1'b0;
    // drain outstanding results, then let the pipeline settle
    while (pending_dims.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("PASS svg_header_dimension_scanner_top");
    else $display("FAIL svg_header_dimension_scanner_top");
    $finish;
  end

endmodule
